// ===== design/vfv_pkg.sv =====
// vfv_pkg: shared types and constants for the voxel face visibility block
// field widths, request and register codes, read steps, controller/datapath structs
// no dependencies

package vfv_pkg;

	localparam int SIDE_XZ_DEF       = 16;
	localparam int COLUMN_HEIGHT_DEF = 64;

	localparam int CELL_X_W  = 4;
	localparam int CELL_Y_W  = 6;
	localparam int CELL_Z_W  = 4;
	localparam int TYPE_W    = 3;
	localparam int MASK_W    = 6;
	localparam int ORIGIN_W  = 13;
	localparam int WORLD_W   = 17;
	localparam int S_DATA_W  = 24;
	localparam int M_DATA_W  = 56;
	localparam int STEP_W    = 3;

	localparam logic [TYPE_W-1:0] AIR = 3'd0;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic REG_ORIGIN_X = 1'b0;
	localparam logic REG_ORIGIN_Z = 1'b1;

	// read steps: the cell itself, then one neighbor per face bit (face = step - 1)
	localparam logic [STEP_W-1:0] RD_CTR  = 3'd0;
	localparam logic [STEP_W-1:0] RD_ZP   = 3'd1;
	localparam logic [STEP_W-1:0] RD_ZN   = 3'd2;
	localparam logic [STEP_W-1:0] RD_XN   = 3'd3;
	localparam logic [STEP_W-1:0] RD_XP   = 3'd4;
	localparam logic [STEP_W-1:0] RD_YP   = 3'd5;
	localparam logic [STEP_W-1:0] RD_YN   = 3'd6;
	localparam logic [STEP_W-1:0] RD_LAST = 3'd7;

	typedef struct packed {
		logic              load;
		logic              clr;
		logic              wr;
		logic              rd;
		logic [STEP_W-1:0] rd_sel;
		logic              cap;
		logic [STEP_W-1:0] cap_sel;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_query;
		logic in_chunk;
	} sts_t;

endpackage

// ===== design/vfv_ram.sv =====
// vfv_ram: generic single-port RAM, one write or read per cycle
// read data registered; no dependencies

module vfv_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/vfv_ctrl.sv =====
// vfv_ctrl: sequencer for clearing pass, write, seven-read query and result handoff
// depends on vfv_pkg

module vfv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	output logic          m_valid,
	input  logic          m_ready,
	input  vfv_pkg::sts_t sts,
	output vfv_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]                  state_q;
	logic [2:0]                  state_d;
	logic [vfv_pkg::STEP_W-1:0]  rd_cnt_q;
	logic [vfv_pkg::STEP_W-1:0]  rd_cnt_d;
	logic                        out_valid_q;

	always_comb begin
		state_d  = state_q;
		rd_cnt_d = rd_cnt_q;
		cmd      = '0;
		s_ready  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.is_query && sts.in_chunk) begin
					rd_cnt_d = vfv_pkg::RD_CTR;
					state_d  = ST_READ;
				end else begin
					cmd.wr  = !sts.is_query && sts.in_chunk;
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				cmd.rd      = (rd_cnt_q != vfv_pkg::RD_LAST);
				cmd.rd_sel  = rd_cnt_q;
				cmd.cap     = (rd_cnt_q != vfv_pkg::RD_CTR);
				cmd.cap_sel = rd_cnt_q - 3'd1;
				rd_cnt_d    = rd_cnt_q + 3'd1;
				if (rd_cnt_q == vfv_pkg::RD_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_cnt_q <= rd_cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid = out_valid_q;

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> (state_q == ST_DECODE))
		else $error("accepted item not decoded");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == ST_IDLE && out_valid_q))
		else $error("result load did not return to idle");

	a_write_gate: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (!sts.is_query && sts.in_chunk && state_q == ST_DECODE))
		else $error("store write outside a valid write item");

	a_read_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && rd_cnt_q == vfv_pkg::RD_LAST) |=> (state_q == ST_DONE))
		else $error("query read sequence did not finish");

endmodule

// ===== design/vfv_dpath.sv =====
// vfv_dpath: item registers, origin registers, voxel store, address steps and result register
// depends on vfv_pkg and vfv_ram

module vfv_dpath #(
	parameter int SIDE_XZ       = vfv_pkg::SIDE_XZ_DEF,
	parameter int COLUMN_HEIGHT = vfv_pkg::COLUMN_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [vfv_pkg::S_DATA_W-1:0]    in_data,
	input  logic                            in_user,
	input  logic                            cfg_we,
	input  logic                            cfg_addr,
	input  logic [vfv_pkg::ORIGIN_W-1:0]    cfg_data,
	input  vfv_pkg::cmd_t                   cmd,
	output vfv_pkg::sts_t                   sts,
	output logic [vfv_pkg::M_DATA_W-1:0]    out_data
);

	localparam int DEPTH        = SIDE_XZ * COLUMN_HEIGHT * SIDE_XZ;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int PLANE_STRIDE = COLUMN_HEIGHT * SIDE_XZ;

	logic                           req_q;
	logic [vfv_pkg::CELL_X_W-1:0]   x_q;
	logic [vfv_pkg::CELL_Y_W-1:0]   y_q;
	logic [vfv_pkg::CELL_Z_W-1:0]   z_q;
	logic [vfv_pkg::TYPE_W-1:0]     nt_q;
	logic [ADDR_W-1:0]              ctr_addr_q;
	logic [vfv_pkg::ORIGIN_W-1:0]   origin_x_q;
	logic [vfv_pkg::ORIGIN_W-1:0]   origin_z_q;
	logic [ADDR_W-1:0]              clr_cnt_q;
	logic [vfv_pkg::TYPE_W-1:0]     type_q;
	logic [vfv_pkg::MASK_W-1:0]     nb_solid_q;
	logic [vfv_pkg::M_DATA_W-1:0]   out_q;

	logic [vfv_pkg::CELL_X_W-1:0]   in_x;
	logic [vfv_pkg::CELL_Y_W-1:0]   in_y;
	logic [vfv_pkg::CELL_Z_W-1:0]   in_z;
	logic [ADDR_W-1:0]              in_addr;
	logic                           in_chunk;
	logic [vfv_pkg::MASK_W-1:0]     nb_in;
	logic [ADDR_W-1:0]              ram_addr;
	logic                           ram_we;
	logic [vfv_pkg::TYPE_W-1:0]     ram_wdata;
	logic [vfv_pkg::TYPE_W-1:0]     ram_rdata;
	logic [vfv_pkg::TYPE_W-1:0]     res_type;
	logic [vfv_pkg::MASK_W-1:0]     res_mask;
	logic [vfv_pkg::WORLD_W-1:0]    world_x;
	logic [vfv_pkg::WORLD_W-1:0]    world_z;

	assign in_x = in_data[3:0];
	assign in_y = in_data[9:4];
	assign in_z = in_data[13:10];

	// cell index = (x * height + y) * side + z
	assign in_addr = ADDR_W'(ADDR_W'(in_x) * ADDR_W'(PLANE_STRIDE))
		+ ADDR_W'(ADDR_W'(in_y) * ADDR_W'(SIDE_XZ)) + ADDR_W'(in_z);

	assign in_chunk = (int'(x_q) < SIDE_XZ) && (int'(y_q) < COLUMN_HEIGHT)
		&& (int'(z_q) < SIDE_XZ);

	assign nb_in[0] = (int'(z_q) + 1 < SIDE_XZ);
	assign nb_in[1] = (z_q != '0);
	assign nb_in[2] = (x_q != '0);
	assign nb_in[3] = (int'(x_q) + 1 < SIDE_XZ);
	assign nb_in[4] = (int'(y_q) + 1 < COLUMN_HEIGHT);
	assign nb_in[5] = (y_q != '0);

	always_comb begin
		ram_addr = ctr_addr_q;
		if (cmd.clr) begin
			ram_addr = clr_cnt_q;
		end else if (cmd.rd) begin
			case (cmd.rd_sel)
				vfv_pkg::RD_CTR: ram_addr = ctr_addr_q;
				vfv_pkg::RD_ZP:  ram_addr = ctr_addr_q + ADDR_W'(1);
				vfv_pkg::RD_ZN:  ram_addr = ctr_addr_q - ADDR_W'(1);
				vfv_pkg::RD_XN:  ram_addr = ctr_addr_q - ADDR_W'(PLANE_STRIDE);
				vfv_pkg::RD_XP:  ram_addr = ctr_addr_q + ADDR_W'(PLANE_STRIDE);
				vfv_pkg::RD_YP:  ram_addr = ctr_addr_q + ADDR_W'(SIDE_XZ);
				vfv_pkg::RD_YN:  ram_addr = ctr_addr_q - ADDR_W'(SIDE_XZ);
				default:         ram_addr = ctr_addr_q;
			endcase
		end
	end

	assign ram_we    = cmd.clr || cmd.wr;
	assign ram_wdata = cmd.clr ? vfv_pkg::AIR : nt_q;

	vfv_ram #(
		.WIDTH(vfv_pkg::TYPE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.addr (ram_addr),
		.we   (ram_we),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= in_user;
			x_q        <= in_x;
			y_q        <= in_y;
			z_q        <= in_z;
			nt_q       <= in_data[16:14];
			ctr_addr_q <= in_addr;
		end
		if (cmd.cap) begin
			if (cmd.cap_sel == vfv_pkg::RD_CTR) begin
				type_q <= ram_rdata;
			end else begin
				nb_solid_q[cmd.cap_sel - 3'd1] <= (ram_rdata != vfv_pkg::AIR)
					&& nb_in[cmd.cap_sel - 3'd1];
			end
		end
		if (cmd.out_load) begin
			out_q <= {7'd0, world_z, y_q, world_x, res_mask, res_type};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
			clr_cnt_q  <= '0;
		end else begin
			if (cfg_we && cfg_addr == vfv_pkg::REG_ORIGIN_X) begin
				origin_x_q <= cfg_data;
			end
			if (cfg_we && cfg_addr == vfv_pkg::REG_ORIGIN_Z) begin
				origin_z_q <= cfg_data;
			end
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
		end
	end

	assign res_type = (req_q == vfv_pkg::REQ_QUERY && in_chunk) ? type_q : vfv_pkg::AIR;
	assign res_mask = (res_type != vfv_pkg::AIR) ? ~nb_solid_q : '0;

	// wraps to the world width
	assign world_x = vfv_pkg::WORLD_W'(
		{{(vfv_pkg::WORLD_W - vfv_pkg::ORIGIN_W){origin_x_q[vfv_pkg::ORIGIN_W-1]}}, origin_x_q}
		* vfv_pkg::WORLD_W'(SIDE_XZ)) + vfv_pkg::WORLD_W'(x_q);
	assign world_z = vfv_pkg::WORLD_W'(
		{{(vfv_pkg::WORLD_W - vfv_pkg::ORIGIN_W){origin_z_q[vfv_pkg::ORIGIN_W-1]}}, origin_z_q}
		* vfv_pkg::WORLD_W'(SIDE_XZ)) + vfv_pkg::WORLD_W'(z_q);

	assign sts.clr_done = (clr_cnt_q == ADDR_W'(DEPTH - 1));
	assign sts.is_query = (req_q == vfv_pkg::REQ_QUERY);
	assign sts.in_chunk = in_chunk;

	assign out_data = out_q;

endmodule

// ===== design/voxel_face_visibility.sv =====
// voxel_face_visibility: top level of the voxel chunk face visibility block
// depends on vfv_pkg, vfv_ctrl, vfv_dpath (which holds vfv_ram)
//
// channel   dir  handshake                 contents
// s_axis    in   s_axis_tvalid/tready      cell item, tuser = req_type
// m_axis    out  m_axis_tvalid/tready      one result per item
// cfg       in   cfg_valid/cfg_ready       cfg_addr selects origin x (0) or z (1)
//
// after reset the store is swept to empty, one cell a cycle, over all SIDE_XZ*COLUMN_HEIGHT*SIDE_XZ
// cells (16384 by default); no item is taken meanwhile, configuration writes are taken
// a write or an out-of-chunk item goes from accept through decode and done back to idle, where the next item is taken
// a query inside the chunk adds seven reads of the single-port voxel store before done
// the result register holds a finished item; a stalled output only blocks the next handoff

module voxel_face_visibility #(
	parameter int SIDE_XZ       = vfv_pkg::SIDE_XZ_DEF,
	parameter int COLUMN_HEIGHT = vfv_pkg::COLUMN_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// cell_x[3:0], cell_y[9:4], cell_z[13:10], new_type[16:14]
	input  logic [vfv_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// req_type[0]
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// cell_type[2:0], face_mask[8:3], world_x[25:9], world_y[31:26], world_z[48:32]
	output logic [vfv_pkg::M_DATA_W-1:0]  m_axis_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_addr,
	input  logic [vfv_pkg::ORIGIN_W-1:0]  cfg_data
);

	vfv_pkg::cmd_t cmd;
	vfv_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	vfv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.sts    (sts),
		.cmd    (cmd)
	);

	vfv_dpath #(
		.SIDE_XZ      (SIDE_XZ),
		.COLUMN_HEIGHT(COLUMN_HEIGHT)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (s_axis_tdata),
		.in_user (s_axis_tuser),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.cmd     (cmd),
		.sts     (sts),
		.out_data(m_axis_tdata)
	);

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for voxel_face_visibility
// drives cell writes and face queries over the stream ports and predicts every result
// depends on vfv_pkg and the voxel_face_visibility rtl
`timescale 1ns / 100ps

module tb_top;

	localparam int SIDE          = vfv_pkg::SIDE_XZ_DEF;
	localparam int HEIGHT        = vfv_pkg::COLUMN_HEIGHT_DEF;
	localparam int STALL_LIMIT   = 100000;
	localparam int ITEMS_PER_SET = 200;

	class voxel_scoreboard;
		typedef struct {
			logic [vfv_pkg::TYPE_W-1:0]   cell_type;
			logic [vfv_pkg::MASK_W-1:0]   face_mask;
			logic [vfv_pkg::WORLD_W-1:0]  world_x;
			logic [vfv_pkg::CELL_Y_W-1:0] world_y;
			logic [vfv_pkg::WORLD_W-1:0]  world_z;
		} face_result_t;

		logic [vfv_pkg::TYPE_W-1:0]          voxels [SIDE*HEIGHT*SIDE];
		logic signed [vfv_pkg::ORIGIN_W-1:0] origin_x;
		logic signed [vfv_pkg::ORIGIN_W-1:0] origin_z;
		face_result_t                        expected_q [$];
		int                                  errors;

		function new();
			foreach (voxels[i])
				voxels[i] = vfv_pkg::AIR;
			origin_x = '0;
			origin_z = '0;
			errors   = 0;
		endfunction

		function int cell_at(int x, int y, int z);
			return (x * HEIGHT + y) * SIDE + z;
		endfunction

		function bit solid(int x, int y, int z);
			if (x < 0 || x >= SIDE || y < 0 || y >= HEIGHT || z < 0 || z >= SIDE)
				return 1'b0;
			return voxels[cell_at(x, y, z)] != vfv_pkg::AIR;
		endfunction

		function void set_origin(logic addr, logic [vfv_pkg::ORIGIN_W-1:0] value);
			if (addr == vfv_pkg::REG_ORIGIN_X)
				origin_x = value;
			else
				origin_z = value;
		endfunction

		function void note_item(logic req, int x, int y, int z,
		                        logic [vfv_pkg::TYPE_W-1:0] nt);
			face_result_t r;
			int           wx;
			int           wz;
			wx          = int'(origin_x) * SIDE + x;
			wz          = int'(origin_z) * SIDE + z;
			r.cell_type = vfv_pkg::AIR;
			r.face_mask = '0;
			r.world_x   = wx[vfv_pkg::WORLD_W-1:0];
			r.world_y   = y[vfv_pkg::CELL_Y_W-1:0];
			r.world_z   = wz[vfv_pkg::WORLD_W-1:0];
			if (x < SIDE && y < HEIGHT && z < SIDE) begin
				if (req == vfv_pkg::REQ_WRITE) begin
					voxels[cell_at(x, y, z)] = nt;
				end else begin
					r.cell_type = voxels[cell_at(x, y, z)];
					if (r.cell_type != vfv_pkg::AIR) begin
						r.face_mask[0] = !solid(x, y, z + 1);
						r.face_mask[1] = !solid(x, y, z - 1);
						r.face_mask[2] = !solid(x - 1, y, z);
						r.face_mask[3] = !solid(x + 1, y, z);
						r.face_mask[4] = !solid(x, y + 1, z);
						r.face_mask[5] = !solid(x, y - 1, z);
					end
				end
			end
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void check_result(logic [vfv_pkg::M_DATA_W-1:0] d);
			face_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, d);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (d[2:0] !== e.cell_type) begin
				$display("%0t: cell_type expected %h actual %h", $time, e.cell_type, d[2:0]);
				errors++;
			end
			if (d[8:3] !== e.face_mask) begin
				$display("%0t: face_mask expected %h actual %h", $time, e.face_mask, d[8:3]);
				errors++;
			end
			if (d[25:9] !== e.world_x) begin
				$display("%0t: world_x expected %h actual %h", $time, e.world_x, d[25:9]);
				errors++;
			end
			if (d[31:26] !== e.world_y) begin
				$display("%0t: world_y expected %h actual %h", $time, e.world_y, d[31:26]);
				errors++;
			end
			if (d[48:32] !== e.world_z) begin
				$display("%0t: world_z expected %h actual %h", $time, e.world_z, d[48:32]);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [vfv_pkg::S_DATA_W-1:0]    s_axis_tdata  = '0;
	logic                            s_axis_tuser  = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [vfv_pkg::M_DATA_W-1:0]    m_axis_tdata;
	logic                            cfg_valid     = 1'b0;
	logic                            cfg_ready;
	logic                            cfg_addr      = 1'b0;
	logic [vfv_pkg::ORIGIN_W-1:0]    cfg_data      = '0;

	voxel_scoreboard sb = new();
	int              idle_cycles   = 0;
	int              no_gap_left   = 0;
	int              ready_hold    = 0;
	int              stall_left    = 0;
	int              cx, cy, cz;

	voxel_face_visibility dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// output side: random stalls, mostly short, some long, with stall-free stretches
	always @(negedge clk) begin
		int r;
		if (stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left--;
		end else if (ready_hold > 0) begin
			m_axis_tready = 1'b1;
			ready_hold--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 8)
				ready_hold = $urandom_range(20, 80);
			else if (r < 12)
				stall_left = $urandom_range(15, 50);
			else if (r < 45)
				stall_left = $urandom_range(1, 3);
			m_axis_tready = (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("voxel_face_visibility regression: fail");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			no_gap_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(input logic req, input int x, input int y, input int z,
	                         input int nt);
		int gap;
		gap = pick_gap();
		repeat (gap) @(negedge clk);
		s_axis_tdata  = {7'd0, nt[2:0], z[3:0], y[5:0], x[3:0]};
		s_axis_tuser  = req;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(req, x, y, z, nt[2:0]);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_reg(input logic addr, input int value);
		cfg_addr  = addr;
		cfg_data  = value[vfv_pkg::ORIGIN_W-1:0];
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_origin(addr, value[vfv_pkg::ORIGIN_W-1:0]);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(negedge clk);
		repeat (15) @(negedge clk);
	endtask

	function automatic int edge_or_any(int top);
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 0;
		if (r < 50)
			return top;
		return $urandom_range(0, top);
	endfunction

	// most items land in a small box so that neighbors are often solid
	task automatic run_random(input int count);
		int x, y, z, nt, r;
		logic req;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 24) == 0) begin
				cx = edge_or_any(SIDE - 4);
				cy = edge_or_any(HEIGHT - 4);
				cz = edge_or_any(SIDE - 4);
			end
			r   = $urandom_range(0, 99);
			req = $urandom_range(0, 1);
			nt  = ($urandom_range(0, 3) == 0) ? vfv_pkg::AIR : $urandom_range(1, 7);
			if (r < 75) begin
				x = cx + $urandom_range(0, 3);
				y = cy + $urandom_range(0, 3);
				z = cz + $urandom_range(0, 3);
			end else begin
				x  = $urandom_range(0, SIDE - 1);
				y  = $urandom_range(0, HEIGHT - 1);
				z  = $urandom_range(0, SIDE - 1);
				nt = $urandom_range(0, 7);
			end
			send_item(req, x, y, z, nt);
		end
	endtask

	initial begin
		int ox, oz;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		cx = 0;
		cy = 0;
		cz = 0;

		write_reg(vfv_pkg::REG_ORIGIN_X, 0);
		write_reg(vfv_pkg::REG_ORIGIN_Z, 0);

		// lone blocks at opposite corners expose every face
		send_item(vfv_pkg::REQ_QUERY, 0, 0, 0, 7);
		send_item(vfv_pkg::REQ_WRITE, 0, 0, 0, 7);
		send_item(vfv_pkg::REQ_QUERY, 0, 0, 0, 0);
		send_item(vfv_pkg::REQ_WRITE, 15, 63, 15, 5);
		send_item(vfv_pkg::REQ_QUERY, 15, 63, 15, 2);
		// touching pair hides the shared faces
		send_item(vfv_pkg::REQ_WRITE, 1, 0, 0, 3);
		send_item(vfv_pkg::REQ_QUERY, 0, 0, 0, 0);
		send_item(vfv_pkg::REQ_QUERY, 1, 0, 0, 0);
		// fully enclosed cell
		send_item(vfv_pkg::REQ_WRITE, 8, 32, 8, 2);
		send_item(vfv_pkg::REQ_WRITE, 8, 32, 9, 1);
		send_item(vfv_pkg::REQ_WRITE, 8, 32, 7, 4);
		send_item(vfv_pkg::REQ_WRITE, 7, 32, 8, 6);
		send_item(vfv_pkg::REQ_WRITE, 9, 32, 8, 7);
		send_item(vfv_pkg::REQ_WRITE, 8, 33, 8, 1);
		send_item(vfv_pkg::REQ_WRITE, 8, 31, 8, 3);
		send_item(vfv_pkg::REQ_QUERY, 8, 32, 8, 7);
		// clearing a cell turns it back to empty
		send_item(vfv_pkg::REQ_WRITE, 0, 0, 0, 0);
		send_item(vfv_pkg::REQ_QUERY, 0, 0, 0, 0);
		send_item(vfv_pkg::REQ_QUERY, 1, 0, 0, 0);

		for (int set = 0; set < 5; set++) begin
			wait_drained();
			case (set)
			0: begin
				ox = -4096;
				oz = 4095;
			end
			1: begin
				ox = 4095;
				oz = -4096;
			end
			2: begin
				ox = -1;
				oz = 1;
			end
			default: begin
				ox = $urandom_range(0, 8191) - 4096;
				oz = $urandom_range(0, 8191) - 4096;
			end
			endcase
			write_reg(vfv_pkg::REG_ORIGIN_X, ox);
			write_reg(vfv_pkg::REG_ORIGIN_Z, oz);
			run_random(ITEMS_PER_SET);
		end

		while (sb.pending() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (sb.errors == 0)
			$display("voxel_face_visibility regression: pass");
		else
			$display("voxel_face_visibility regression: fail");
		$finish;
	end

endmodule
